>>> rtl/qsfc_pkg.sv
`default_nettype none
package qsfc_pkg;

  // Field widths
  localparam int unsigned OP_W      = 2;
  localparam int unsigned ID_W      = 12;
  localparam int unsigned LEN_W     = 16;
  localparam int unsigned BYTE_W    = 62;
  localparam int unsigned MAXS_W    = 30;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [OP_W-1:0] {
    OP_OPEN = 2'd0,
    OP_SEND = 2'd1,
    OP_RECV = 2'd2,
    OP_RSVD = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 3'd0,
    ST_NO_ID        = 3'd1,
    ST_INVALID      = 3'd2,
    ST_STREAM_LIMIT = 3'd3,
    ST_CONN_LIMIT   = 3'd4,
    ST_DIRECTION    = 3'd5
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IS_SERVER       = 3'd0,
    CFG_PEER_MAX_BIDI   = 3'd1,
    CFG_PEER_MAX_UNI    = 3'd2,
    CFG_PEER_DATA_UNI   = 3'd3,
    CFG_PEER_DATA_BIDI  = 3'd4,
    CFG_LOCAL_DATA_BIDI = 3'd5,
    CFG_LOCAL_DATA_UNI  = 3'd6,
    CFG_CONN_LIMIT      = 3'd7
  } cfg_idx_t;

  typedef enum logic [1:0] {
    S_CLEAR = 2'd0,
    S_IDLE  = 2'd1,
    S_EXEC  = 2'd2
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic clear_we;
    logic capture;
    logic commit;
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clear_last;
  } dp_sts_t;

endpackage
`default_nettype wire

>>> rtl/qsfc_ctrl.sv
`default_nettype none
module qsfc_ctrl (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_tvalid,
  output logic                   in_tready,
  output logic                   out_tvalid,
  input  wire                    out_tready,
  output qsfc_pkg::ctrl_cmd_t    cmd,
  input  qsfc_pkg::dp_sts_t      sts
);

  qsfc_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  // Output slot can take a result this cycle
  assign out_free = !out_valid_r || out_tready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      qsfc_pkg::S_CLEAR: if (sts.clear_last) state_nxt = qsfc_pkg::S_IDLE;
      qsfc_pkg::S_IDLE:  if (in_tvalid) state_nxt = qsfc_pkg::S_EXEC;
      qsfc_pkg::S_EXEC:  if (out_free) state_nxt = qsfc_pkg::S_IDLE;
      default:           state_nxt = qsfc_pkg::S_CLEAR;
    endcase
  end

  // Commands
  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      qsfc_pkg::S_CLEAR: cmd.clear_we = 1'b1;
      qsfc_pkg::S_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid;
      end
      qsfc_pkg::S_EXEC:  cmd.commit = out_free;
      default:           cmd = '0;
    endcase
  end

  // Result valid: set on commit, drop when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if (cmd.commit) out_valid_nxt = 1'b1;
    else if (out_tready)     out_valid_nxt = 1'b0;
    else                     out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= qsfc_pkg::S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == qsfc_pkg::S_EXEC))
    else $error("accepted item did not enter execute");

  a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_tvalid)
    else $error("committed result not presented");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> !cmd.commit)
    else $error("pending result overwritten");

endmodule
`default_nettype wire

>>> rtl/qsfc_dp.sv
`default_nettype none
module qsfc_dp #(
  parameter int unsigned STREAM_SLOTS = 256
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  qsfc_pkg::ctrl_cmd_t                 cmd,
  output qsfc_pkg::dp_sts_t                   sts,
  input  wire                                 cfg_we,
  input  wire [qsfc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire [qsfc_pkg::BYTE_W-1:0]          cfg_data,
  input  wire [qsfc_pkg::OP_W-1:0]            op_i,
  input  wire                                 uni_i,
  input  wire [qsfc_pkg::ID_W-1:0]            id_i,
  input  wire [qsfc_pkg::LEN_W-1:0]           len_i,
  output logic [qsfc_pkg::STATUS_W-1:0]       status_o,
  output logic [qsfc_pkg::ID_W-1:0]           new_id_o
);

  localparam int unsigned AW  = $clog2(STREAM_SLOTS);
  localparam int unsigned CW  = $clog2((STREAM_SLOTS + 3) / 4 + 1);
  localparam int unsigned BW  = qsfc_pkg::BYTE_W;
  localparam int unsigned OIW = CW + 2;

  // Configuration registers
  logic              srv_r;
  logic [qsfc_pkg::MAXS_W-1:0] max_bidi_r, max_uni_r;
  logic [BW-1:0]     peer_uni_r, peer_bidi_r, local_bidi_r, local_uni_r, conn_lim_r;

  // Connection state
  logic [CW-1:0]     bidi_cnt_r, uni_cnt_r;
  logic [BW-1:0]     conn_sent_r, conn_recv_r;

  // Captured item
  qsfc_pkg::op_t     op_r;
  logic              uni_r;
  logic [qsfc_pkg::ID_W-1:0]  id_r;
  logic [qsfc_pkg::LEN_W-1:0] len_r;

  // Stream tables and registered read data
  logic [BW-1:0]     mem_sent [STREAM_SLOTS];
  logic [BW-1:0]     mem_recv [STREAM_SLOTS];
  logic [BW-1:0]     mem_lim  [STREAM_SLOTS];
  logic              mem_open [STREAM_SLOTS];
  logic [BW-1:0]     sent_rd_r, recv_rd_r, lim_rd_r;
  logic              open_rd_r;

  // Clearing pass
  logic [AW-1:0]     clr_cnt_r;

  // Results
  qsfc_pkg::status_t out_status_r;
  logic [qsfc_pkg::ID_W-1:0]  out_id_r;

  // Execute-stage combinational signals
  qsfc_pkg::status_t status_c;
  logic [OIW-1:0]    open_id;
  logic [31:0]       open_id32;
  logic              peer, valid, ok;
  logic [BW:0]       len_x, s_sum, ts_sum, r_sum, tr_sum;
  logic [BW-1:0]     recv_lim;
  logic [AW-1:0]     rd_addr, wr_addr;
  logic              sent_we, recv_we, lim_we, open_we;
  logic [BW-1:0]     sent_wd, recv_wd, lim_wd;
  logic              open_wd;

  assign sts.clear_last = (clr_cnt_r == AW'(STREAM_SLOTS - 1));
  assign rd_addr        = id_i[AW-1:0];

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      srv_r        <= 1'b0;
      max_bidi_r   <= '0;
      max_uni_r    <= '0;
      peer_uni_r   <= '0;
      peer_bidi_r  <= '0;
      local_bidi_r <= '0;
      local_uni_r  <= '0;
      conn_lim_r   <= '0;
    end else if (cfg_we) begin
      unique case (qsfc_pkg::cfg_idx_t'(cfg_index))
        qsfc_pkg::CFG_IS_SERVER:       srv_r        <= cfg_data[0];
        qsfc_pkg::CFG_PEER_MAX_BIDI:   max_bidi_r   <= cfg_data[qsfc_pkg::MAXS_W-1:0];
        qsfc_pkg::CFG_PEER_MAX_UNI:    max_uni_r    <= cfg_data[qsfc_pkg::MAXS_W-1:0];
        qsfc_pkg::CFG_PEER_DATA_UNI:   peer_uni_r   <= cfg_data;
        qsfc_pkg::CFG_PEER_DATA_BIDI:  peer_bidi_r  <= cfg_data;
        qsfc_pkg::CFG_LOCAL_DATA_BIDI: local_bidi_r <= cfg_data;
        qsfc_pkg::CFG_LOCAL_DATA_UNI:  local_uni_r  <= cfg_data;
        qsfc_pkg::CFG_CONN_LIMIT:      conn_lim_r   <= cfg_data;
        default:                       srv_r        <= srv_r;
      endcase
    end
  end

  // Capture the accepted item
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= qsfc_pkg::op_t'(op_i);
      uni_r <= uni_i;
      id_r  <= id_i;
      len_r <= len_i;
    end
  end

  // Check limits on the captured item and the table read
  always_comb begin
    open_id   = uni_r ? {uni_cnt_r, 1'b1, srv_r} : {bidi_cnt_r, 1'b0, srv_r};
    open_id32 = 32'(open_id);
    peer      = (id_r[0] != srv_r);
    valid     = (32'(id_r) < 32'(STREAM_SLOTS)) && (peer || open_rd_r);
    len_x     = (BW+1)'(len_r);
    s_sum     = {1'b0, sent_rd_r} + len_x;
    ts_sum    = {1'b0, conn_sent_r} + len_x;
    r_sum     = {1'b0, recv_rd_r} + len_x;
    tr_sum    = {1'b0, conn_recv_r} + len_x;
    priority if (!peer)  recv_lim = local_bidi_r;
    else if (id_r[1])    recv_lim = local_uni_r;
    else                 recv_lim = peer_bidi_r;

    status_c = qsfc_pkg::ST_OK;
    unique case (op_r)
      qsfc_pkg::OP_OPEN: begin
        if (uni_r ? (32'(uni_cnt_r) >= 32'(max_uni_r))
                  : (32'(bidi_cnt_r) >= 32'(max_bidi_r)))
          status_c = qsfc_pkg::ST_NO_ID;
        else if (open_id32 >= 32'(STREAM_SLOTS))
          status_c = qsfc_pkg::ST_NO_ID;
      end
      qsfc_pkg::OP_SEND: begin
        priority if (len_r == '0)                    status_c = qsfc_pkg::ST_OK;
        else if (!valid)                             status_c = qsfc_pkg::ST_INVALID;
        else if (s_sum > {1'b0, lim_rd_r})           status_c = qsfc_pkg::ST_STREAM_LIMIT;
        else if (ts_sum > {1'b0, conn_lim_r})        status_c = qsfc_pkg::ST_CONN_LIMIT;
        else                                         status_c = qsfc_pkg::ST_OK;
      end
      qsfc_pkg::OP_RECV: begin
        priority if (!valid)                         status_c = qsfc_pkg::ST_INVALID;
        else if (!peer && id_r[1])                   status_c = qsfc_pkg::ST_DIRECTION;
        else if (r_sum > {1'b0, recv_lim})           status_c = qsfc_pkg::ST_STREAM_LIMIT;
        else if (tr_sum > {1'b0, conn_lim_r})        status_c = qsfc_pkg::ST_CONN_LIMIT;
        else                                         status_c = qsfc_pkg::ST_OK;
      end
      default: status_c = qsfc_pkg::ST_INVALID;
    endcase
    ok = (status_c == qsfc_pkg::ST_OK);
  end

  // Table write port: clearing pass or commit
  always_comb begin
    wr_addr = id_r[AW-1:0];
    sent_we = 1'b0;
    recv_we = 1'b0;
    lim_we  = 1'b0;
    open_we = 1'b0;
    sent_wd = s_sum[BW-1:0];
    recv_wd = r_sum[BW-1:0];
    lim_wd  = uni_r ? peer_uni_r : peer_bidi_r;
    open_wd = 1'b1;
    priority if (cmd.clear_we) begin
      wr_addr = clr_cnt_r;
      sent_we = 1'b1;
      recv_we = 1'b1;
      lim_we  = 1'b1;
      open_we = 1'b1;
      sent_wd = '0;
      recv_wd = '0;
      lim_wd  = '0;
      open_wd = 1'b0;
    end else if (cmd.commit && ok) begin
      unique case (op_r)
        qsfc_pkg::OP_OPEN: begin
          wr_addr = open_id32[AW-1:0];
          lim_we  = 1'b1;
          open_we = 1'b1;
        end
        qsfc_pkg::OP_SEND: sent_we = (len_r != '0);
        qsfc_pkg::OP_RECV: recv_we = 1'b1;
        default:           sent_we = 1'b0;
      endcase
    end else begin
      sent_we = 1'b0;
    end
  end

  // Stream tables
  always_ff @(posedge clk) begin
    if (sent_we) mem_sent[wr_addr] <= sent_wd;
    if (recv_we) mem_recv[wr_addr] <= recv_wd;
    if (lim_we)  mem_lim[wr_addr]  <= lim_wd;
    if (open_we) mem_open[wr_addr] <= open_wd;
    if (cmd.capture) begin
      sent_rd_r <= mem_sent[rd_addr];
      recv_rd_r <= mem_recv[rd_addr];
      lim_rd_r  <= mem_lim[rd_addr];
      open_rd_r <= mem_open[rd_addr];
    end
  end

  // Counters and connection totals
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      bidi_cnt_r  <= '0;
      uni_cnt_r   <= '0;
      conn_sent_r <= '0;
      conn_recv_r <= '0;
    end else begin
      if (cmd.clear_we) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (cmd.commit && ok) begin
        unique case (op_r)
          qsfc_pkg::OP_OPEN: begin
            if (uni_r) uni_cnt_r  <= uni_cnt_r + 1'b1;
            else       bidi_cnt_r <= bidi_cnt_r + 1'b1;
          end
          qsfc_pkg::OP_SEND: conn_sent_r <= ts_sum[BW-1:0];
          qsfc_pkg::OP_RECV: conn_recv_r <= tr_sum[BW-1:0];
          default:           conn_sent_r <= conn_sent_r;
        endcase
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status_r <= status_c;
      out_id_r     <= (ok && op_r == qsfc_pkg::OP_OPEN) ? open_id32[qsfc_pkg::ID_W-1:0] : '0;
    end
  end

  assign status_o = out_status_r;
  assign new_id_o = out_id_r;

endmodule
`default_nettype wire

>>> rtl/quic_stream_flow_control_table_core.sv
`default_nettype none
// Channel  Direction  Handshake               Payload
// in       slave      in_tvalid / in_tready   tuser: opcode; tdata: uni, stream_id, byte_count
// out      master     out_tvalid / out_tready tdata: status, new_stream_id
// cfg      slave      cfg_valid / cfg_ready   cfg_index, cfg_data (always ready)
//
// Each item is accepted, which issues the stream table read, and then
// executed, which checks limits and writes the table back.
// A result waiting in the output register holds execute until it is taken.
// After reset a clearing pass zeroes the tables, with no items accepted;
// configuration writes are taken throughout.
module quic_stream_flow_control_table_core #(
  parameter int unsigned STREAM_SLOTS = 256
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_tvalid,
  output logic                               in_tready,
  input  wire [31:0]                         in_tdata,  // open_unidirectional, stream_id, byte_count
  input  wire [qsfc_pkg::OP_W-1:0]           in_tuser,  // opcode
  output logic                               out_tvalid,
  input  wire                                out_tready,
  output logic [15:0]                        out_tdata, // status, new_stream_id
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire [qsfc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire [qsfc_pkg::BYTE_W-1:0]         cfg_data
);

  qsfc_pkg::ctrl_cmd_t             cmd;
  qsfc_pkg::dp_sts_t               sts;
  logic [qsfc_pkg::STATUS_W-1:0]   status;
  logic [qsfc_pkg::ID_W-1:0]       new_id;

  assign cfg_ready = 1'b1;

  qsfc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  qsfc_dp #(
    .STREAM_SLOTS (STREAM_SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_we    (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .op_i      (in_tuser),
    .uni_i     (in_tdata[0]),
    .id_i      (in_tdata[12:1]),
    .len_i     (in_tdata[28:13]),
    .status_o  (status),
    .new_id_o  (new_id)
  );

  // Pack result fields
  assign out_tdata = {1'b0, new_id, status};

endmodule
`default_nettype wire
